// ===== rtl/core/mtle_pkg.sv =====
`default_nettype none

package mtle_pkg;

    localparam int TERMINALS  = 3;
    localparam int LINE_BYTES = 128;

    // line memory holds two banks per terminal
    localparam int MEM_DEPTH = TERMINALS * 2 * LINE_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LEN_W     = $clog2(LINE_BYTES);
    localparam int LIM_W     = $clog2(LINE_BYTES + 1);
    localparam int TERM_W    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    // command codes
    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_ENTER     = 8'd10;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] term;
        logic [7:0] key;
        logic [7:0] maxb;
    } item_t;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             rdy;
        logic [LEN_W-1:0] pos;
    } term_state_t;

    typedef struct packed {
        logic              en;
        logic [1:0]        term;
        term_state_t       st;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } update_t;

    typedef struct packed {
        logic [1:0] status;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic [7:0] read_byte;
        logic       read_last;
    } result_t;

    function automatic logic [ADDR_W-1:0] mem_addr(
        input logic [TERM_W-1:0] term,
        input logic              bank,
        input logic [LEN_W-1:0]  pos
    );
        logic [ADDR_W-1:0] row;
        row = ADDR_W'({term, bank});
        return ADDR_W'(row * ADDR_W'(LINE_BYTES)) + ADDR_W'(pos);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtle_ram.sv =====
`default_nettype none

module mtle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtle_state.sv =====
`default_nettype none

module mtle_state (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mtle_pkg::update_t    upd,
    input  wire logic [1:0]           cur_term,
    input  wire logic [1:0]           ahead_term,
    output mtle_pkg::term_state_t     cur_st,
    output mtle_pkg::term_state_t     ahead_st
);

    mtle_pkg::term_state_t st_reg  [mtle_pkg::TERMINALS];
    mtle_pkg::term_state_t st_next [mtle_pkg::TERMINALS];

    always_comb
    begin
        for (int i = 0; i < mtle_pkg::TERMINALS; i++)
        begin
            st_next[i] = st_reg[i];
            if (upd.en && int'(upd.term) == i)
            begin
                st_next[i] = upd.st;
            end
        end
    end

    // state of the item in flight, and look-ahead for the item being taken
    always_comb
    begin
        cur_st   = '0;
        ahead_st = '0;
        for (int i = 0; i < mtle_pkg::TERMINALS; i++)
        begin
            if (int'(cur_term) == i)
            begin
                cur_st = st_reg[i];
            end
            if (int'(ahead_term) == i)
            begin
                ahead_st = st_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mtle_pkg::TERMINALS; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < mtle_pkg::TERMINALS; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtle_edit.sv =====
`default_nettype none

module mtle_edit (
    input  wire mtle_pkg::item_t       item,
    input  wire mtle_pkg::term_state_t cur_st,
    input  wire logic [7:0]            line_byte,
    output mtle_pkg::update_t          upd,
    output mtle_pkg::result_t          res
);

    logic [mtle_pkg::LIM_W-1:0] limit;
    logic [mtle_pkg::LIM_W-1:0] pos_inc;
    mtle_pkg::term_state_t      st;

    always_comb
    begin
        upd = '0;
        res = '0;
        st  = cur_st;

        // reader limit clipped to one line, zero taken as one
        if (int'(item.maxb) > mtle_pkg::LINE_BYTES)
        begin
            limit = mtle_pkg::LIM_W'(mtle_pkg::LINE_BYTES);
        end
        else if (item.maxb == 8'd0)
        begin
            limit = mtle_pkg::LIM_W'(1);
        end
        else
        begin
            limit = mtle_pkg::LIM_W'(item.maxb);
        end
        pos_inc = mtle_pkg::LIM_W'(cur_st.pos) + 1'b1;

        if (int'(item.term) < mtle_pkg::TERMINALS)
        begin
            case (item.cmd)
                mtle_pkg::CMD_KEY:
                begin
                    if (item.key == mtle_pkg::KEY_BACKSPACE)
                    begin
                        if (cur_st.len != '0)
                        begin
                            st.len         = cur_st.len - 1'b1;
                            upd.en         = 1'b1;
                            res.echo_valid = 1'b1;
                            res.echo_byte  = mtle_pkg::KEY_BACKSPACE;
                        end
                    end
                    else if (item.key == mtle_pkg::KEY_ENTER)
                    begin
                        upd.wr_en      = 1'b1;
                        upd.wr_addr    = mtle_pkg::mem_addr(
                            item.term[mtle_pkg::TERM_W-1:0], cur_st.bank, cur_st.len);
                        upd.wr_data    = mtle_pkg::KEY_ENTER;
                        st.bank        = ~cur_st.bank;
                        st.len         = '0;
                        st.rdy         = 1'b1;
                        st.pos         = '0;
                        upd.en         = 1'b1;
                        res.echo_valid = 1'b1;
                        res.echo_byte  = mtle_pkg::KEY_ENTER;
                    end
                    else if (int'(cur_st.len) >= mtle_pkg::LINE_BYTES - 1)
                    begin
                        res.status = mtle_pkg::ST_FULL;
                    end
                    else
                    begin
                        upd.wr_en      = 1'b1;
                        upd.wr_addr    = mtle_pkg::mem_addr(
                            item.term[mtle_pkg::TERM_W-1:0], cur_st.bank, cur_st.len);
                        upd.wr_data    = item.key;
                        st.len         = cur_st.len + 1'b1;
                        upd.en         = 1'b1;
                        res.echo_valid = 1'b1;
                        res.echo_byte  = item.key;
                    end
                end
                mtle_pkg::CMD_READ:
                begin
                    if (!cur_st.rdy)
                    begin
                        res.status = mtle_pkg::ST_NOT_READY;
                    end
                    else
                    begin
                        res.read_byte = line_byte;
                        upd.en        = 1'b1;
                        if (line_byte == mtle_pkg::KEY_ENTER || pos_inc >= limit)
                        begin
                            res.read_last = 1'b1;
                            st.rdy        = 1'b0;
                            st.pos        = '0;
                        end
                        else
                        begin
                            st.pos = cur_st.pos + 1'b1;
                        end
                    end
                end
                mtle_pkg::CMD_CLEAR:
                begin
                    st     = '0;
                    upd.en = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        upd.term = item.term;
        upd.st   = st;
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_terminal_line_editor.sv =====
`default_nettype none

// Canonical line editor for several terminals sharing one line memory of two
// banks per terminal. Every item gives exactly one result. The block takes one
// item per cycle while the output register is not held by out_ready; an item
// waits in stage one on the registered read port of the line memory: the read
// address is issued as the item is taken, and the edit, the memory write and
// the terminal state update happen as the item leaves stage one for the output
// register. Per-terminal state is forwarded to the item being taken, and a
// same-cycle write to the byte being read is bypassed, so back-to-back items
// on one terminal see each other's effects. The line memory needs no clearing
// after reset: a reader only reaches bytes written since the line was started.
module multi_terminal_line_editor (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] cmd,
    input  wire logic [1:0] term_sel,
    input  wire logic [7:0] key_byte,
    input  wire logic [7:0] max_bytes,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic            echo_valid,
    output logic [7:0]      echo_byte,
    output logic [7:0]      read_byte,
    output logic            read_last
);

    // stage one: item waiting on its memory read
    logic                        p_valid_reg;
    logic                        p_valid_next;
    mtle_pkg::item_t             p_item_reg;
    logic                        byp_hit_reg;
    logic [7:0]                  byp_data_reg;

    // output register
    logic                        o_valid_reg;
    logic                        o_valid_next;
    mtle_pkg::result_t           o_res_reg;

    logic                        adv;
    logic                        in_accept;
    mtle_pkg::term_state_t       cur_st;
    mtle_pkg::term_state_t       ahead_st;
    mtle_pkg::update_t           upd;
    mtle_pkg::update_t           upd_commit;
    mtle_pkg::result_t           res;
    logic [mtle_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  ram_rdata;
    logic [7:0]                  line_byte;

    // stage one moves on when the output register is free or being emptied
    assign adv       = p_valid_reg && (!o_valid_reg || out_ready);
    assign in_ready  = !p_valid_reg || adv;
    assign in_accept = in_valid && in_ready;

    // edits take effect only when the item leaves stage one
    always_comb
    begin
        upd_commit       = upd;
        upd_commit.en    = upd.en && adv;
        upd_commit.wr_en = upd.wr_en && adv;
    end

    // read address from the look-ahead state, reader bank is the other one
    always_comb
    begin
        if (int'(term_sel) < mtle_pkg::TERMINALS)
        begin
            rd_addr = mtle_pkg::mem_addr(term_sel[mtle_pkg::TERM_W-1:0],
                                         ~ahead_st.bank, ahead_st.pos);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign line_byte = byp_hit_reg ? byp_data_reg : ram_rdata;

    mtle_ram #(
        .WIDTH (8),
        .DEPTH (mtle_pkg::MEM_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (upd_commit.wr_en),
        .waddr (upd_commit.wr_addr),
        .wdata (upd_commit.wr_data),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    mtle_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd_commit),
        .cur_term   (p_item_reg.term),
        .ahead_term (term_sel),
        .cur_st     (cur_st),
        .ahead_st   (ahead_st)
    );

    mtle_edit u_edit (
        .item      (p_item_reg),
        .cur_st    (cur_st),
        .line_byte (line_byte),
        .upd       (upd),
        .res       (res)
    );

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (in_accept)
        begin
            p_valid_next = 1'b1;
        end
        else if (adv)
        begin
            p_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_item_reg.cmd  <= cmd;
            p_item_reg.term <= term_sel;
            p_item_reg.key  <= key_byte;
            p_item_reg.maxb <= max_bytes;
            // write landing on the byte just read: memory returns the old byte
            byp_hit_reg     <= upd_commit.wr_en && (upd_commit.wr_addr == rd_addr);
            byp_data_reg    <= upd_commit.wr_data;
        end
        if (adv)
        begin
            o_res_reg <= res;
        end
    end

    assign out_valid  = o_valid_reg;
    assign status     = o_res_reg.status;
    assign echo_valid = o_res_reg.echo_valid;
    assign echo_byte  = o_res_reg.echo_byte;
    assign read_byte  = o_res_reg.read_byte;
    assign read_last  = o_res_reg.read_last;

    // an item is never taken over a stalled stage one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && p_valid_reg |-> adv)
        else $error("item accepted while stage one is blocked");

    // rejected keys and empty reads neither echo nor end a read
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mtle_pkg::ST_OK |-> !echo_valid && !read_last)
        else $error("error status with echo or read end");

    // the line being edited always keeps a slot for the newline
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ahead_st.len) <= mtle_pkg::LINE_BYTES - 1)
        else $error("line length past the newline slot");

endmodule

`default_nettype wire
